>>> rtl/core/tsi_pkg.sv
package tsi_pkg;

    // Field and datapath widths
    localparam int PRICE_W = 32;
    localparam int ALPHA_W = 17;
    localparam int EMA_W   = 48;
    localparam int MOM_W   = 41;   // signed momentum, price delta shifted by 8
    localparam int AMOM_W  = 40;   // magnitude of the momentum
    localparam int DIFF_W  = 42;   // x - ema, both within +-2^40
    localparam int HALF_W  = 21;   // multiplier operand split
    localparam int PROD_W  = 38;   // one partial product
    localparam int ACC_W   = 59;   // full (x - ema) * alpha
    localparam int MAG_W   = 41;   // |num| and den, both at most 2^40
    localparam int Q_W     = 15;   // quotient bits below saturation
    localparam int NUM_W   = 56;   // |num| * 25600
    localparam int CNT_W   = 4;
    localparam int TSI_W   = 16;
    localparam int PC_W    = 5;

    // Constants
    localparam logic [ALPHA_W-1:0] ALPHA_ONE       = 17'd65536;
    localparam logic [ALPHA_W-1:0] LONG_ALPHA_RST  = 17'd5041;
    localparam logic [ALPHA_W-1:0] SHORT_ALPHA_RST = 17'd9362;
    localparam logic [Q_W-1:0]     PCT_Q8          = 15'd25600;
    localparam logic signed [TSI_W-1:0] TSI_FULL   = 16'sd25600;
    localparam logic [CNT_W-1:0]   DIV_STEPS_M1    = 4'd14;

    // Configuration register indexes
    localparam logic REG_LONG_ALPHA  = 1'b0;
    localparam logic REG_SHORT_ALPHA = 1'b1;

    // Sample phase
    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_RUN    = 2'd2;

    // Datapath operations
    typedef logic [3:0] op_t;
    localparam op_t OP_NOP      = 4'd0;
    localparam op_t OP_TAKE     = 4'd1;
    localparam op_t OP_DIFF     = 4'd2;
    localparam op_t OP_MUL_LO   = 4'd3;
    localparam op_t OP_MUL_HI   = 4'd4;
    localparam op_t OP_WB       = 4'd5;
    localparam op_t OP_DIV_PREP = 4'd6;
    localparam op_t OP_DIV_INIT = 4'd7;
    localparam op_t OP_DIV_STEP = 4'd8;
    localparam op_t OP_OUT      = 4'd9;

    // Average select
    typedef logic [1:0] sel_t;
    localparam sel_t SEL_LONG_NUM  = 2'd0;
    localparam sel_t SEL_LONG_DEN  = 2'd1;
    localparam sel_t SEL_SHORT_NUM = 2'd2;
    localparam sel_t SEL_SHORT_DEN = 2'd3;

    // Sequencer conditions
    typedef logic [2:0] cond_t;
    localparam cond_t C_NEVER    = 3'd0;
    localparam cond_t C_ALWAYS   = 3'd1;
    localparam cond_t C_NO_INPUT = 3'd2;
    localparam cond_t C_FIRST    = 3'd3;
    localparam cond_t C_SEEDED   = 3'd4;
    localparam cond_t C_CNT_NZ   = 3'd5;
    localparam cond_t C_OUT_BUSY = 3'd6;

    typedef logic [PC_W-1:0] pc_t;
    localparam pc_t ADDR_TAKE     = 5'd0;
    localparam pc_t ADDR_DIV_PREP = 5'd19;
    localparam pc_t ADDR_DIV_STEP = 5'd21;
    localparam pc_t ADDR_OUT      = 5'd22;

    // One control word: hold while wait_c, else jump on jump_c, else step
    typedef struct packed {
        op_t   op;
        sel_t  sel;
        cond_t wait_c;
        cond_t jump_c;
        pc_t   target;
    } ctrl_t;

    function automatic ctrl_t cw(input op_t op, input sel_t sel, input cond_t wait_c,
                                 input cond_t jump_c, input pc_t target);
        ctrl_t w;
        w.op     = op;
        w.sel    = sel;
        w.wait_c = wait_c;
        w.jump_c = jump_c;
        w.target = target;
        return w;
    endfunction

    // Program store
    function automatic ctrl_t ucode_rom(input pc_t addr);
        ctrl_t w;
        unique case (addr)
            5'd0:  w = cw(OP_TAKE,     SEL_LONG_NUM,  C_NO_INPUT, C_NEVER,  ADDR_TAKE);
            5'd1:  w = cw(OP_NOP,      SEL_LONG_NUM,  C_NEVER,    C_FIRST,  ADDR_TAKE);
            5'd2:  w = cw(OP_NOP,      SEL_LONG_NUM,  C_NEVER,    C_SEEDED, ADDR_DIV_PREP);
            // long numerator average
            5'd3:  w = cw(OP_DIFF,     SEL_LONG_NUM,  C_NEVER,    C_NEVER,  ADDR_TAKE);
            5'd4:  w = cw(OP_MUL_LO,   SEL_LONG_NUM,  C_NEVER,    C_NEVER,  ADDR_TAKE);
            5'd5:  w = cw(OP_MUL_HI,   SEL_LONG_NUM,  C_NEVER,    C_NEVER,  ADDR_TAKE);
            5'd6:  w = cw(OP_WB,       SEL_LONG_NUM,  C_NEVER,    C_NEVER,  ADDR_TAKE);
            // long denominator average
            5'd7:  w = cw(OP_DIFF,     SEL_LONG_DEN,  C_NEVER,    C_NEVER,  ADDR_TAKE);
            5'd8:  w = cw(OP_MUL_LO,   SEL_LONG_DEN,  C_NEVER,    C_NEVER,  ADDR_TAKE);
            5'd9:  w = cw(OP_MUL_HI,   SEL_LONG_DEN,  C_NEVER,    C_NEVER,  ADDR_TAKE);
            5'd10: w = cw(OP_WB,       SEL_LONG_DEN,  C_NEVER,    C_NEVER,  ADDR_TAKE);
            // short numerator average
            5'd11: w = cw(OP_DIFF,     SEL_SHORT_NUM, C_NEVER,    C_NEVER,  ADDR_TAKE);
            5'd12: w = cw(OP_MUL_LO,   SEL_SHORT_NUM, C_NEVER,    C_NEVER,  ADDR_TAKE);
            5'd13: w = cw(OP_MUL_HI,   SEL_SHORT_NUM, C_NEVER,    C_NEVER,  ADDR_TAKE);
            5'd14: w = cw(OP_WB,       SEL_SHORT_NUM, C_NEVER,    C_NEVER,  ADDR_TAKE);
            // short denominator average
            5'd15: w = cw(OP_DIFF,     SEL_SHORT_DEN, C_NEVER,    C_NEVER,  ADDR_TAKE);
            5'd16: w = cw(OP_MUL_LO,   SEL_SHORT_DEN, C_NEVER,    C_NEVER,  ADDR_TAKE);
            5'd17: w = cw(OP_MUL_HI,   SEL_SHORT_DEN, C_NEVER,    C_NEVER,  ADDR_TAKE);
            5'd18: w = cw(OP_WB,       SEL_SHORT_DEN, C_NEVER,    C_NEVER,  ADDR_TAKE);
            // ratio
            5'd19: w = cw(OP_DIV_PREP, SEL_SHORT_DEN, C_NEVER,    C_NEVER,  ADDR_TAKE);
            5'd20: w = cw(OP_DIV_INIT, SEL_SHORT_DEN, C_NEVER,    C_NEVER,  ADDR_TAKE);
            5'd21: w = cw(OP_DIV_STEP, SEL_SHORT_DEN, C_CNT_NZ,   C_NEVER,  ADDR_TAKE);
            5'd22: w = cw(OP_OUT,      SEL_SHORT_DEN, C_OUT_BUSY, C_ALWAYS, ADDR_TAKE);
            default: w = cw(OP_NOP,    SEL_LONG_NUM,  C_NEVER,    C_ALWAYS, ADDR_TAKE);
        endcase
        return w;
    endfunction

endpackage

>>> rtl/core/true_strength_index_stream_core.sv
// True strength index over a stream of Q24.8 prices. Each transfer on the input side
// carries one price; the block keeps the previous price and four 48-bit averages of the
// momentum and its magnitude (long then short, weights set by long_alpha and short_alpha
// in Q0.16), and returns 100 * num / den as signed Q7.8, truncated toward zero and held
// to +-25600, or 0 when the denominator is zero. The first price after reset only loads
// the previous price and gives no result; the second seeds the averages and gives a
// result. A small microcode program runs one item at a time: four average updates, each
// multiplying x - ema by alpha in two 21-bit halves, then a 15-step restoring divider.
// The result sits in an output register, so the next price is taken while it waits.
// Write the alpha registers only while the block is idle.
module true_strength_index_stream_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // input channel
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [tsi_pkg::PRICE_W-1:0]            price,
    // output channel
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [tsi_pkg::TSI_W-1:0]       tsi_value,
    // configuration
    input  logic                                   cfg_we,
    input  logic                                   cfg_index,
    input  logic [tsi_pkg::ALPHA_W-1:0]            cfg_data
);

    // Sequencer
    tsi_pkg::pc_t   pc_reg, pc_next;
    tsi_pkg::ctrl_t ctrl;
    logic           in_transfer;
    logic           out_busy;
    logic           wait_hit, jump_hit;

    // Control state
    logic [1:0]                  phase_reg, phase_next;
    logic                        seed_reg, seed_next;
    logic [tsi_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                        out_valid_reg, out_valid_next;
    logic [tsi_pkg::ALPHA_W-1:0] long_alpha_reg, short_alpha_reg;

    // Stream state
    logic [tsi_pkg::PRICE_W-1:0]      last_price_reg, last_price_next;
    logic signed [tsi_pkg::EMA_W-1:0] lnum_reg, lnum_next;
    logic signed [tsi_pkg::EMA_W-1:0] lden_reg, lden_next;
    logic signed [tsi_pkg::EMA_W-1:0] snum_reg, snum_next;
    logic signed [tsi_pkg::EMA_W-1:0] sden_reg, sden_next;

    // Working registers
    logic signed [tsi_pkg::MOM_W-1:0]  mom_reg, mom_next;
    logic [tsi_pkg::AMOM_W-1:0]        amom_reg, amom_next;
    logic signed [tsi_pkg::DIFF_W-1:0] diff_reg, diff_next;
    logic signed [tsi_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic [tsi_pkg::MAG_W-1:0]         mag_reg, mag_next;
    logic [tsi_pkg::MAG_W-1:0]         den_reg, den_next;
    logic                              neg_reg, neg_next;
    logic                              zden_reg, zden_next;
    logic                              sat_reg, sat_next;
    logic [tsi_pkg::MAG_W-1:0]         rem_reg, rem_next;
    logic [tsi_pkg::Q_W-1:0]           nlow_reg, nlow_next;
    logic [tsi_pkg::Q_W-1:0]           quo_reg, quo_next;
    logic signed [tsi_pkg::TSI_W-1:0]  tsi_reg, tsi_next;

    // Datapath nets
    logic signed [tsi_pkg::PRICE_W:0]    delta;
    logic [tsi_pkg::PRICE_W-1:0]         abs_delta;
    logic signed [tsi_pkg::MOM_W-1:0]    mom_in;
    logic [tsi_pkg::AMOM_W-1:0]          amom_in;
    logic signed [tsi_pkg::EMA_W-1:0]    ema_cur, x_cur, diff_full, snum_abs;
    logic [tsi_pkg::ALPHA_W-1:0]         alpha_sel, alpha_cl;
    logic [tsi_pkg::PROD_W-1:0]          lo_prod;
    logic signed [tsi_pkg::PROD_W:0]     hi_prod;
    logic signed [tsi_pkg::EMA_W-1:0]    ema_upd;
    logic [tsi_pkg::NUM_W-1:0]           num_prod;
    logic [tsi_pkg::MAG_W:0]             trial;
    logic                                trial_ge;
    logic [tsi_pkg::MAG_W:0]             trial_sub;
    logic signed [tsi_pkg::TSI_W-1:0]    q_mag, result;

    assign in_stall    = (pc_reg != tsi_pkg::ADDR_TAKE);
    assign in_transfer = in_valid && !in_stall;
    assign out_busy    = out_valid_reg && out_stall;
    assign out_valid   = out_valid_reg;
    assign tsi_value   = tsi_reg;

    // Control word fetch and branch resolution
    function automatic logic cond_eval(input tsi_pkg::cond_t c, input logic no_in,
                                       input logic first, input logic seeded,
                                       input logic cnt_nz, input logic busy);
        logic r;
        case (c)
            tsi_pkg::C_ALWAYS:   r = 1'b1;
            tsi_pkg::C_NO_INPUT: r = no_in;
            tsi_pkg::C_FIRST:    r = first;
            tsi_pkg::C_SEEDED:   r = seeded;
            tsi_pkg::C_CNT_NZ:   r = cnt_nz;
            tsi_pkg::C_OUT_BUSY: r = busy;
            default:             r = 1'b0;
        endcase
        return r;
    endfunction

    always_comb
    begin
        ctrl     = tsi_pkg::ucode_rom(pc_reg);
        wait_hit = cond_eval(ctrl.wait_c, !in_transfer, phase_reg == tsi_pkg::PH_SECOND,
                             seed_reg, cnt_reg != '0, out_busy);
        jump_hit = cond_eval(ctrl.jump_c, !in_transfer, phase_reg == tsi_pkg::PH_SECOND,
                             seed_reg, cnt_reg != '0, out_busy);
        if (wait_hit)
            pc_next = pc_reg;
        else if (jump_hit)
            pc_next = ctrl.target;
        else
            pc_next = pc_reg + 1'b1;
    end

    // Momentum from the new price
    always_comb
    begin
        delta     = $signed({1'b0, price}) - $signed({1'b0, last_price_reg});
        abs_delta = (price < last_price_reg) ? (last_price_reg - price) : (price - last_price_reg);
        mom_in    = $signed({delta, 8'b0});
        amom_in   = {abs_delta, 8'b0};
    end

    // Operand selection for the average being updated
    always_comb
    begin
        case (ctrl.sel)
            tsi_pkg::SEL_LONG_NUM:
            begin
                ema_cur   = lnum_reg;
                x_cur     = {{(tsi_pkg::EMA_W-tsi_pkg::MOM_W){mom_reg[tsi_pkg::MOM_W-1]}}, mom_reg};
                alpha_sel = long_alpha_reg;
            end
            tsi_pkg::SEL_LONG_DEN:
            begin
                ema_cur   = lden_reg;
                x_cur     = $signed({{(tsi_pkg::EMA_W-tsi_pkg::AMOM_W){1'b0}}, amom_reg});
                alpha_sel = long_alpha_reg;
            end
            tsi_pkg::SEL_SHORT_NUM:
            begin
                ema_cur   = snum_reg;
                x_cur     = lnum_reg;
                alpha_sel = short_alpha_reg;
            end
            default:
            begin
                ema_cur   = sden_reg;
                x_cur     = lden_reg;
                alpha_sel = short_alpha_reg;
            end
        endcase
        alpha_cl  = (alpha_sel > tsi_pkg::ALPHA_ONE) ? tsi_pkg::ALPHA_ONE : alpha_sel;
        diff_full = x_cur - ema_cur;
        lo_prod   = diff_reg[tsi_pkg::HALF_W-1:0] * alpha_cl;
        hi_prod   = $signed(diff_reg[tsi_pkg::DIFF_W-1:tsi_pkg::HALF_W])
                    * $signed({1'b0, alpha_cl});
        // floor of acc / 2^16 is an arithmetic shift
        ema_upd   = ema_cur + {{(tsi_pkg::EMA_W-(tsi_pkg::ACC_W-16)){acc_reg[tsi_pkg::ACC_W-1]}},
                               acc_reg[tsi_pkg::ACC_W-1:16]};
    end

    // Divider and result formatting
    always_comb
    begin
        snum_abs  = snum_reg[tsi_pkg::EMA_W-1] ? -snum_reg : snum_reg;
        num_prod  = mag_reg * tsi_pkg::PCT_Q8;
        trial     = {rem_reg, nlow_reg[tsi_pkg::Q_W-1]};
        trial_ge  = trial >= {1'b0, den_reg};
        trial_sub = trial - {1'b0, den_reg};
        q_mag     = sat_reg ? tsi_pkg::TSI_FULL : $signed({1'b0, quo_reg});
        if (zden_reg)
            result = '0;
        else if (neg_reg)
            result = -q_mag;
        else
            result = q_mag;
    end

    // Operation decode
    always_comb
    begin
        phase_next      = phase_reg;
        seed_next       = seed_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && out_stall;
        last_price_next = last_price_reg;
        lnum_next       = lnum_reg;
        lden_next       = lden_reg;
        snum_next       = snum_reg;
        sden_next       = sden_reg;
        mom_next        = mom_reg;
        amom_next       = amom_reg;
        diff_next       = diff_reg;
        acc_next        = acc_reg;
        mag_next        = mag_reg;
        den_next        = den_reg;
        neg_next        = neg_reg;
        zden_next       = zden_reg;
        sat_next        = sat_reg;
        rem_next        = rem_reg;
        nlow_next       = nlow_reg;
        quo_next        = quo_reg;
        tsi_next        = tsi_reg;
        unique case (ctrl.op)
            tsi_pkg::OP_NOP:
            begin
            end
            tsi_pkg::OP_TAKE:
            begin
                if (in_transfer)
                begin
                    last_price_next = price;
                    mom_next        = mom_in;
                    amom_next       = amom_in;
                    seed_next       = (phase_reg == tsi_pkg::PH_SECOND);
                    if (phase_reg == tsi_pkg::PH_FIRST)
                        phase_next = tsi_pkg::PH_SECOND;
                    else if (phase_reg == tsi_pkg::PH_SECOND)
                    begin
                        phase_next = tsi_pkg::PH_RUN;
                        lnum_next  = {{(tsi_pkg::EMA_W-tsi_pkg::MOM_W){mom_in[tsi_pkg::MOM_W-1]}},
                                      mom_in};
                        snum_next  = {{(tsi_pkg::EMA_W-tsi_pkg::MOM_W){mom_in[tsi_pkg::MOM_W-1]}},
                                      mom_in};
                        lden_next  = $signed({{(tsi_pkg::EMA_W-tsi_pkg::AMOM_W){1'b0}}, amom_in});
                        sden_next  = $signed({{(tsi_pkg::EMA_W-tsi_pkg::AMOM_W){1'b0}}, amom_in});
                    end
                end
            end
            tsi_pkg::OP_DIFF:
                diff_next = diff_full[tsi_pkg::DIFF_W-1:0];
            tsi_pkg::OP_MUL_LO:
                acc_next = $signed({{(tsi_pkg::ACC_W-tsi_pkg::PROD_W){1'b0}}, lo_prod});
            tsi_pkg::OP_MUL_HI:
                acc_next = acc_reg + $signed({hi_prod[tsi_pkg::PROD_W-1:0],
                                              {tsi_pkg::HALF_W{1'b0}}});
            tsi_pkg::OP_WB:
            begin
                case (ctrl.sel)
                    tsi_pkg::SEL_LONG_NUM:  lnum_next = ema_upd;
                    tsi_pkg::SEL_LONG_DEN:  lden_next = ema_upd;
                    tsi_pkg::SEL_SHORT_NUM: snum_next = ema_upd;
                    default:                sden_next = ema_upd;
                endcase
            end
            tsi_pkg::OP_DIV_PREP:
            begin
                mag_next  = snum_abs[tsi_pkg::MAG_W-1:0];
                neg_next  = snum_reg[tsi_pkg::EMA_W-1];
                zden_next = sden_reg[tsi_pkg::EMA_W-1] || (sden_reg == '0);
                den_next  = sden_reg[tsi_pkg::MAG_W-1:0];
            end
            tsi_pkg::OP_DIV_INIT:
            begin
                sat_next  = (mag_reg >= den_reg);
                rem_next  = num_prod[tsi_pkg::NUM_W-1:tsi_pkg::Q_W];
                nlow_next = num_prod[tsi_pkg::Q_W-1:0];
                quo_next  = '0;
                cnt_next  = tsi_pkg::DIV_STEPS_M1;
            end
            tsi_pkg::OP_DIV_STEP:
            begin
                rem_next  = trial_ge ? trial_sub[tsi_pkg::MAG_W-1:0] : trial[tsi_pkg::MAG_W-1:0];
                nlow_next = {nlow_reg[tsi_pkg::Q_W-2:0], 1'b0};
                quo_next  = {quo_reg[tsi_pkg::Q_W-2:0], trial_ge};
                cnt_next  = cnt_reg - 1'b1;
            end
            tsi_pkg::OP_OUT:
            begin
                if (!out_busy)
                begin
                    out_valid_next = 1'b1;
                    tsi_next       = result;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control and stream state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg          <= tsi_pkg::ADDR_TAKE;
            phase_reg       <= tsi_pkg::PH_FIRST;
            seed_reg        <= 1'b0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
            last_price_reg  <= '0;
            lnum_reg        <= '0;
            lden_reg        <= '0;
            snum_reg        <= '0;
            sden_reg        <= '0;
        end
        else
        begin
            pc_reg          <= pc_next;
            phase_reg       <= phase_next;
            seed_reg        <= seed_next;
            cnt_reg         <= cnt_next;
            out_valid_reg   <= out_valid_next;
            last_price_reg  <= last_price_next;
            lnum_reg        <= lnum_next;
            lden_reg        <= lden_next;
            snum_reg        <= snum_next;
            sden_reg        <= sden_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_alpha_reg  <= tsi_pkg::LONG_ALPHA_RST;
            short_alpha_reg <= tsi_pkg::SHORT_ALPHA_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tsi_pkg::REG_LONG_ALPHA:  long_alpha_reg  <= cfg_data;
                tsi_pkg::REG_SHORT_ALPHA: short_alpha_reg <= cfg_data;
            endcase
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        mom_reg  <= mom_next;
        amom_reg <= amom_next;
        diff_reg <= diff_next;
        acc_reg  <= acc_next;
        mag_reg  <= mag_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        zden_reg <= zden_next;
        sat_reg  <= sat_next;
        rem_reg  <= rem_next;
        nlow_reg <= nlow_next;
        quo_reg  <= quo_next;
        tsi_reg  <= tsi_next;
    end

`ifndef NO_ASSERTIONS
    // a result is only loaded from the output step of the program
    a_out_from_program: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(pc_reg) == tsi_pkg::ADDR_OUT))
        else $error("result loaded outside the output step");

    // delivered index stays within +-100 percent
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((tsi_reg <= tsi_pkg::TSI_FULL) && (tsi_reg >= -tsi_pkg::TSI_FULL)))
        else $error("index out of range");

    // magnitude averages never go negative
    a_den_sign: assert property (@(posedge clk) disable iff (!rst_n)
        !lden_reg[tsi_pkg::EMA_W-1] && !sden_reg[tsi_pkg::EMA_W-1])
        else $error("denominator average went negative");

    // restoring divider keeps its remainder below the divisor
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        ((pc_reg == tsi_pkg::ADDR_DIV_STEP) && !sat_reg && !zden_reg) |-> (rem_reg < den_reg))
        else $error("divider remainder not below divisor");
`endif

endmodule
